### rtl/timestamp_pair_matcher_top_assert.svh
`ifndef TIMESTAMP_PAIR_MATCHER_TOP_ASSERT_SVH
`define TIMESTAMP_PAIR_MATCHER_TOP_ASSERT_SVH

// check a condition on every clock edge outside reset
`define TPM_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// check that a condition implies another in the same cycle
`define TPM_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

### rtl/tpm_pkg.sv
package tpm_pkg;

    localparam int PEND_DEPTH = 16;
    localparam int DONE_DEPTH = 32;
    localparam int PEND_IDX_W = $clog2(PEND_DEPTH);
    localparam int DONE_IDX_W = $clog2(DONE_DEPTH);
    localparam int CNT_W      = $clog2(2 * PEND_DEPTH + 32);
    localparam int CFG_IDX_W  = 2;

    localparam logic [1:0] OP_RAW   = 2'd0;
    localparam logic [1:0] OP_FUSED = 2'd1;
    localparam logic [1:0] OP_FLUSH = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    localparam logic [1:0] CAUSE_MERGE    = 2'd0;
    localparam logic [1:0] CAUSE_MISMATCH = 2'd1;
    localparam logic [1:0] CAUSE_LATE     = 2'd2;
    localparam logic [1:0] CAUSE_NOFUSED  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LIFETIME = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAXPEND  = 2'd2;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [63:0] stamp_key;
        logic [47:0] now_time;
        logic [15:0] item_handle;
        logic [15:0] point_count;
        logic [15:0] color_count;
    } t_in_word;

    typedef struct packed {
        logic [63:0] out_key;
        logic [15:0] raw_handle;
        logic [15:0] fused_handle;
        logic        fused_taken;
        logic [1:0]  cause;
        logic [47:0] wait_ticks;
        logic        last;
    } t_out_word;

    typedef struct packed {
        logic we;
        logic clr;
        logic drop_stale;
    } t_pend_ctl;

    typedef struct packed {
        logic [63:0] key;
        logic [47:0] info;
        logic [47:0] arrival;
        logic [47:0] aux;
    } t_pend_data;

    typedef struct packed {
        logic [63:0] key;
        logic [47:0] now;
        logic [31:0] holdoff;
    } t_pend_probe;

    typedef struct packed {
        logic        valid;
        logic [63:0] key;
        logic [47:0] info;
        logic [47:0] arrival;
        logic [47:0] aux;
        logic        due;
    } t_pend_view;

    typedef struct packed {
        logic we;
        logic prune;
    } t_done_ctl;

    typedef struct packed {
        logic [63:0] key;
        logic [47:0] expiry;
    } t_done_data;

    typedef struct packed {
        logic [63:0] key;
        logic [47:0] now;
    } t_done_probe;

    typedef struct packed {
        logic        valid;
        logic [63:0] key;
        logic [47:0] expiry;
    } t_done_view;

    function automatic logic [47:0] sat_add48(input logic [47:0] a, input logic [31:0] b);
        logic [48:0] s;
        s = {1'b0, a} + {17'd0, b};
        return s[48] ? '1 : s[47:0];
    endfunction

    function automatic logic [47:0] elapsed(input logic [47:0] from, input logic [47:0] to);
        return (to >= from) ? (to - from) : '0;
    endfunction

endpackage

### rtl/tpm_pend_cell.sv
module tpm_pend_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tpm_pkg::t_pend_ctl   i_ctl,
    input  tpm_pkg::t_pend_data  i_wdata,
    input  tpm_pkg::t_pend_probe i_probe,
    input  logic                 i_hit_in,
    input  logic                 i_free_in,
    output tpm_pkg::t_pend_view  o_view,
    output logic                 o_hit_out,
    output logic                 o_free_out,
    output logic                 o_hit_first,
    output logic                 o_free_first
);
    import tpm_pkg::*;

    logic        r_valid;
    t_pend_data  r_data;
    logic        w_hit;
    logic        w_stale;

    assign w_hit   = r_valid && (r_data.key == i_probe.key);
    assign w_stale = r_valid && (i_probe.now >= r_data.arrival) &&
                     ((i_probe.now - r_data.arrival) >= {16'd0, i_probe.holdoff});

    assign o_hit_first  = w_hit && !i_hit_in;
    assign o_hit_out    = i_hit_in || w_hit;
    assign o_free_first = !r_valid && !i_free_in;
    assign o_free_out   = i_free_in || !r_valid;

    assign o_view.valid   = r_valid;
    assign o_view.key     = r_data.key;
    assign o_view.info    = r_data.info;
    assign o_view.arrival = r_data.arrival;
    assign o_view.aux     = r_data.aux;
    assign o_view.due     = r_valid && (i_probe.now >= r_data.aux);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.we) begin
            r_valid <= 1'b1;
        end else if (i_ctl.clr || (i_ctl.drop_stale && w_stale)) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_data <= i_wdata;
        end
    end

endmodule

### rtl/tpm_done_cell.sv
module tpm_done_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tpm_pkg::t_done_ctl   i_ctl,
    input  tpm_pkg::t_done_data  i_wdata,
    input  tpm_pkg::t_done_probe i_probe,
    input  logic                 i_hit_in,
    input  logic                 i_free_in,
    output tpm_pkg::t_done_view  o_view,
    output logic                 o_hit_out,
    output logic                 o_free_out,
    output logic                 o_hit_first,
    output logic                 o_free_first
);
    import tpm_pkg::*;

    logic        r_valid;
    t_done_data  r_data;
    logic        w_hit;

    assign w_hit = r_valid && (r_data.key == i_probe.key);

    assign o_hit_first  = w_hit && !i_hit_in;
    assign o_hit_out    = i_hit_in || w_hit;
    assign o_free_first = !r_valid && !i_free_in;
    assign o_free_out   = i_free_in || !r_valid;

    assign o_view.valid  = r_valid;
    assign o_view.key    = r_data.key;
    assign o_view.expiry = r_data.expiry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.we) begin
            r_valid <= 1'b1;
        end else if (i_ctl.prune && r_valid && (i_probe.now >= r_data.expiry)) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_data <= i_wdata;
        end
    end

endmodule

### rtl/timestamp_pair_matcher_top.sv
// Pairs raw and fused detection words by timestamp key through two rows of sixteen
// pending cells and a row of thirty-two remembered-key cells. Key lookups, due and
// stale checks run in every cell at once; the oldest-entry search for eviction and
// the smallest-expiry search of a full done row walk the cells one slot a cycle.
// An arrival passes prune, lookup and room check to insert, or records its key after
// a pair; each eviction round rescans the pending rows, and a new key scans the done
// row when it must displace a remembered one. A flush publishes each due raw entry in
// turn, remembering its key before emitting it, and goes idle when none is due. A
// finished word waits in the output register while the next input word is taken.
`include "timestamp_pair_matcher_top_assert.svh"

module timestamp_pair_matcher_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  tpm_pkg::t_in_word                  i_in_word,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output tpm_pkg::t_out_word                 o_out_word,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [tpm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [31:0]                        i_cfg_data
);
    import tpm_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_PRUNE, S_LOOK, S_ROOM_CHK, S_ROOM_SCAN, S_ROOM_EVICT, S_INSERT,
        S_REM_LOOK, S_REM_SCAN, S_REM_WRITE, S_EMIT, S_FL_NEXT
    } t_state;

    t_state r_state, n_state;

    logic [31:0] r_holdoff, r_lifetime;
    logic [4:0]  r_max;

    logic [1:0]  r_op, n_op;
    logic [63:0] r_key, n_key;
    logic [47:0] r_now, n_now;
    logic [15:0] r_handle, n_handle, r_points, n_points, r_colors, n_colors;
    logic        r_ovw, n_ovw, r_live, n_live;
    logic [PEND_IDX_W-1:0] r_tgt, n_tgt, r_idx, n_idx, r_rb_idx, n_rb_idx, r_fb_idx, n_fb_idx;
    logic        r_rb_ok, n_rb_ok, r_fb_ok, n_fb_ok;
    logic [47:0] r_rb_arr, n_rb_arr, r_fb_arr, n_fb_arr;
    logic [DONE_IDX_W-1:0] r_didx, n_didx, r_dslot, n_dslot;
    logic [47:0] r_db_exp, n_db_exp;
    logic [63:0] r_rkey, n_rkey;
    t_out_word   r_res, n_res;
    logic [PEND_DEPTH-1:0] r_due, n_due;
    logic        r_out_valid, n_out_valid;
    t_out_word   r_out_word, n_out_word;

    t_pend_ctl   w_raw_ctl [PEND_DEPTH];
    t_pend_ctl   w_fus_ctl [PEND_DEPTH];
    t_done_ctl   w_done_ctl [DONE_DEPTH];
    t_pend_view  w_raw_view [PEND_DEPTH];
    t_pend_view  w_fus_view [PEND_DEPTH];
    t_done_view  w_done_view [DONE_DEPTH];
    t_pend_data  w_pdata;
    t_pend_probe w_pprobe;
    t_done_data  w_ddata;
    t_done_probe w_dprobe;

    logic [PEND_DEPTH:0] w_raw_hit_c, w_raw_free_c, w_fus_hit_c, w_fus_free_c;
    logic [DONE_DEPTH:0] w_done_hit_c, w_done_free_c;
    logic [PEND_DEPTH-1:0] w_raw_hit1, w_raw_free1, w_fus_hit1, w_fus_free1, w_raw_due;
    logic [DONE_DEPTH-1:0] w_done_hit1, w_done_free1;
    logic [PEND_IDX_W-1:0] w_raw_hit_idx, w_raw_free_idx, w_fus_hit_idx, w_fus_free_idx;
    logic [PEND_IDX_W-1:0] w_due_idx, w_raw_addr, w_fus_addr;
    logic [DONE_IDX_W-1:0] w_done_hit_idx, w_done_free_idx;
    logic [PEND_DEPTH-1:0] w_due_bit;
    t_pend_view  w_raw_sel, w_fus_sel;
    t_done_view  w_done_sel;
    logic [CNT_W-1:0] w_total, w_lim;

    logic        w_ok, w_late, w_rc, w_fc, w_r_any, w_f_any, w_evict_raw, w_load;
    logic [47:0] w_ra, w_fa;

    assign w_raw_hit_c[0]   = 1'b0;
    assign w_raw_free_c[0]  = 1'b0;
    assign w_fus_hit_c[0]   = 1'b0;
    assign w_fus_free_c[0]  = 1'b0;
    assign w_done_hit_c[0]  = 1'b0;
    assign w_done_free_c[0] = 1'b0;

    assign w_pdata.key     = r_key;
    assign w_pdata.arrival = r_now;
    assign w_pdata.info    = (r_op == OP_RAW) ? {16'd0, r_handle, r_points}
                                              : {r_handle, r_points, r_colors};
    assign w_pdata.aux     = sat_add48(r_now, r_holdoff);
    assign w_pprobe.key     = r_key;
    assign w_pprobe.now     = r_now;
    assign w_pprobe.holdoff = r_holdoff;
    assign w_ddata.key     = r_rkey;
    assign w_ddata.expiry  = sat_add48(r_now, r_lifetime);
    assign w_dprobe.key    = r_rkey;
    assign w_dprobe.now    = r_now;

    for (genvar g = 0; g < PEND_DEPTH; g++) begin : g_pend
        tpm_pend_cell u_raw (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_raw_ctl[g]),
            .i_wdata      (w_pdata),
            .i_probe      (w_pprobe),
            .i_hit_in     (w_raw_hit_c[g]),
            .i_free_in    (w_raw_free_c[g]),
            .o_view       (w_raw_view[g]),
            .o_hit_out    (w_raw_hit_c[g+1]),
            .o_free_out   (w_raw_free_c[g+1]),
            .o_hit_first  (w_raw_hit1[g]),
            .o_free_first (w_raw_free1[g])
        );
        tpm_pend_cell u_fus (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_fus_ctl[g]),
            .i_wdata      (w_pdata),
            .i_probe      (w_pprobe),
            .i_hit_in     (w_fus_hit_c[g]),
            .i_free_in    (w_fus_free_c[g]),
            .o_view       (w_fus_view[g]),
            .o_hit_out    (w_fus_hit_c[g+1]),
            .o_free_out   (w_fus_free_c[g+1]),
            .o_hit_first  (w_fus_hit1[g]),
            .o_free_first (w_fus_free1[g])
        );
        assign w_raw_due[g] = w_raw_view[g].due;
    end

    for (genvar g = 0; g < DONE_DEPTH; g++) begin : g_done
        tpm_done_cell u_done (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_done_ctl[g]),
            .i_wdata      (w_ddata),
            .i_probe      (w_dprobe),
            .i_hit_in     (w_done_hit_c[g]),
            .i_free_in    (w_done_free_c[g]),
            .o_view       (w_done_view[g]),
            .o_hit_out    (w_done_hit_c[g+1]),
            .o_free_out   (w_done_free_c[g+1]),
            .o_hit_first  (w_done_hit1[g]),
            .o_free_first (w_done_free1[g])
        );
    end

    always_comb begin
        w_raw_hit_idx  = '0;
        w_raw_free_idx = '0;
        w_fus_hit_idx  = '0;
        w_fus_free_idx = '0;
        w_due_idx      = '0;
        w_due_bit      = '0;
        w_total        = '0;
        for (int i = 0; i < PEND_DEPTH; i++) begin
            if (w_raw_hit1[i])  w_raw_hit_idx  |= PEND_IDX_W'(i);
            if (w_raw_free1[i]) w_raw_free_idx |= PEND_IDX_W'(i);
            if (w_fus_hit1[i])  w_fus_hit_idx  |= PEND_IDX_W'(i);
            if (w_fus_free1[i]) w_fus_free_idx |= PEND_IDX_W'(i);
            w_total = w_total + CNT_W'(w_raw_view[i].valid) + CNT_W'(w_fus_view[i].valid);
        end
        for (int i = PEND_DEPTH - 1; i >= 0; i--) begin
            if (r_due[i]) begin
                w_due_idx = PEND_IDX_W'(i);
            end
        end
        w_due_bit[w_due_idx] = 1'b1;
        w_total = w_total + CNT_W'(r_live);
        w_done_hit_idx  = '0;
        w_done_free_idx = '0;
        for (int i = 0; i < DONE_DEPTH; i++) begin
            if (w_done_hit1[i])  w_done_hit_idx  |= DONE_IDX_W'(i);
            if (w_done_free1[i]) w_done_free_idx |= DONE_IDX_W'(i);
        end
    end

    assign w_lim = (CNT_W'(r_max) > CNT_W'(PEND_DEPTH)) ? CNT_W'(PEND_DEPTH) : CNT_W'(r_max);

    assign w_raw_addr = (r_state == S_ROOM_SCAN) ? r_idx :
                        (r_state == S_FL_NEXT)   ? w_due_idx : w_raw_hit_idx;
    assign w_fus_addr = (r_state == S_ROOM_SCAN) ? r_idx : w_fus_hit_idx;
    assign w_raw_sel  = w_raw_view[w_raw_addr];
    assign w_fus_sel  = w_fus_view[w_fus_addr];
    assign w_done_sel = w_done_view[r_didx];

    assign w_ok   = (r_op == OP_RAW)
                  ? ((w_fus_sel.info[31:16] == r_points) && (w_fus_sel.info[15:0] >= r_points))
                  : ((r_points == w_raw_sel.info[15:0]) && (r_colors >= w_raw_sel.info[15:0]));
    assign w_late = r_now > w_raw_sel.aux;

    assign w_rc = r_live && (r_op == OP_RAW) && (!r_rb_ok || (r_now < r_rb_arr));
    assign w_fc = r_live && (r_op == OP_FUSED) && (!r_fb_ok || (r_now < r_fb_arr));
    assign w_r_any = r_rb_ok || w_rc;
    assign w_f_any = r_fb_ok || w_fc;
    assign w_ra = w_rc ? r_now : (r_rb_ok ? r_rb_arr : '0);
    assign w_fa = w_fc ? r_now : (r_fb_ok ? r_fb_arr : '0);
    assign w_evict_raw = !w_f_any || (w_r_any && (w_ra <= w_fa));

    assign w_load = (r_state == S_EMIT) && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_key    = r_key;
        n_now    = r_now;
        n_handle = r_handle;
        n_points = r_points;
        n_colors = r_colors;
        n_ovw    = r_ovw;
        n_live   = r_live;
        n_tgt    = r_tgt;
        n_idx    = r_idx;
        n_rb_ok  = r_rb_ok;
        n_rb_idx = r_rb_idx;
        n_rb_arr = r_rb_arr;
        n_fb_ok  = r_fb_ok;
        n_fb_idx = r_fb_idx;
        n_fb_arr = r_fb_arr;
        n_didx   = r_didx;
        n_dslot  = r_dslot;
        n_db_exp = r_db_exp;
        n_rkey   = r_rkey;
        n_res    = r_res;
        n_due    = r_due;
        for (int i = 0; i < PEND_DEPTH; i++) begin
            w_raw_ctl[i] = '0;
            w_fus_ctl[i] = '0;
        end
        for (int i = 0; i < DONE_DEPTH; i++) begin
            w_done_ctl[i] = '0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op     = i_in_word.opcode;
                    n_key    = i_in_word.stamp_key;
                    n_rkey   = i_in_word.stamp_key;
                    n_now    = i_in_word.now_time;
                    n_handle = i_in_word.item_handle;
                    n_points = i_in_word.point_count;
                    n_colors = i_in_word.color_count;
                    if (i_in_word.opcode != OP_NONE) begin
                        n_state = S_PRUNE;
                    end
                end
            end
            S_PRUNE: begin
                for (int i = 0; i < DONE_DEPTH; i++) begin
                    w_done_ctl[i].prune = 1'b1;
                end
                n_state = S_LOOK;
            end
            S_LOOK: begin
                n_res.out_key      = r_key;
                n_res.fused_taken  = 1'b0;
                n_res.fused_handle = '0;
                n_res.last         = 1'b1;
                n_live = 1'b1;
                n_ovw  = 1'b0;
                n_state = S_ROOM_CHK;
                if (r_op == OP_FLUSH) begin
                    for (int i = 0; i < PEND_DEPTH; i++) begin
                        w_fus_ctl[i].drop_stale = 1'b1;
                    end
                    n_due   = w_raw_due;
                    n_live  = 1'b0;
                    n_state = S_FL_NEXT;
                end else if (w_done_hit_c[DONE_DEPTH]) begin
                    n_live  = 1'b0;
                    n_state = S_IDLE;
                end else if (r_op == OP_RAW) begin
                    if (w_fus_hit_c[PEND_DEPTH]) begin
                        n_res.raw_handle   = r_handle;
                        n_res.fused_handle = w_ok ? w_fus_sel.info[47:32] : '0;
                        n_res.fused_taken  = w_ok;
                        n_res.cause        = w_ok ? CAUSE_MERGE : CAUSE_MISMATCH;
                        n_res.wait_ticks   = '0;
                        w_fus_ctl[w_fus_hit_idx].clr = 1'b1;
                        n_live  = 1'b0;
                        n_state = S_REM_LOOK;
                    end else if (w_raw_hit_c[PEND_DEPTH]) begin
                        n_ovw  = 1'b1;
                        n_live = 1'b0;
                        n_tgt  = w_raw_hit_idx;
                    end
                end else begin
                    if (w_raw_hit_c[PEND_DEPTH]) begin
                        n_res.raw_handle   = w_raw_sel.info[31:16];
                        n_res.fused_handle = (w_ok && !w_late) ? r_handle : '0;
                        n_res.fused_taken  = w_ok && !w_late;
                        n_res.cause        = w_late ? CAUSE_LATE
                                           : (w_ok ? CAUSE_MERGE : CAUSE_MISMATCH);
                        n_res.wait_ticks   = elapsed(w_raw_sel.arrival, r_now);
                        w_raw_ctl[w_raw_hit_idx].clr = 1'b1;
                        n_live  = 1'b0;
                        n_state = S_REM_LOOK;
                    end else if (w_fus_hit_c[PEND_DEPTH]) begin
                        n_ovw  = 1'b1;
                        n_live = 1'b0;
                        n_tgt  = w_fus_hit_idx;
                    end
                end
            end
            S_ROOM_CHK: begin
                if (w_total <= w_lim) begin
                    n_state = S_INSERT;
                end else begin
                    n_idx   = '0;
                    n_rb_ok = 1'b0;
                    n_fb_ok = 1'b0;
                    n_state = S_ROOM_SCAN;
                end
            end
            S_ROOM_SCAN: begin
                if (w_raw_sel.valid && (!r_rb_ok || (w_raw_sel.arrival < r_rb_arr))) begin
                    n_rb_ok  = 1'b1;
                    n_rb_idx = r_idx;
                    n_rb_arr = w_raw_sel.arrival;
                end
                if (w_fus_sel.valid && (!r_fb_ok || (w_fus_sel.arrival < r_fb_arr))) begin
                    n_fb_ok  = 1'b1;
                    n_fb_idx = r_idx;
                    n_fb_arr = w_fus_sel.arrival;
                end
                n_idx = r_idx + 1'b1;
                if (r_idx == PEND_IDX_W'(PEND_DEPTH - 1)) begin
                    n_state = S_ROOM_EVICT;
                end
            end
            S_ROOM_EVICT: begin
                if (w_evict_raw) begin
                    if (w_rc) begin
                        n_live = 1'b0;
                    end else if (r_rb_ok) begin
                        w_raw_ctl[r_rb_idx].clr = 1'b1;
                    end
                end else begin
                    if (w_fc) begin
                        n_live = 1'b0;
                    end else if (r_fb_ok) begin
                        w_fus_ctl[r_fb_idx].clr = 1'b1;
                    end
                end
                n_state = S_ROOM_CHK;
            end
            S_INSERT: begin
                if (r_op == OP_RAW) begin
                    if (r_ovw) begin
                        w_raw_ctl[r_tgt].we = 1'b1;
                    end else if (r_live) begin
                        w_raw_ctl[w_raw_free_idx].we = 1'b1;
                    end
                end else begin
                    if (r_ovw) begin
                        w_fus_ctl[r_tgt].we = 1'b1;
                    end else if (r_live) begin
                        w_fus_ctl[w_fus_free_idx].we = 1'b1;
                    end
                end
                n_live  = 1'b0;
                n_state = S_IDLE;
            end
            S_REM_LOOK: begin
                if (w_done_hit_c[DONE_DEPTH]) begin
                    n_dslot = w_done_hit_idx;
                    n_state = S_REM_WRITE;
                end else if (w_done_free_c[DONE_DEPTH]) begin
                    n_dslot = w_done_free_idx;
                    n_state = S_REM_WRITE;
                end else begin
                    n_didx  = '0;
                    n_state = S_REM_SCAN;
                end
            end
            S_REM_SCAN: begin
                if ((r_didx == '0) || (w_done_sel.expiry < r_db_exp)) begin
                    n_dslot  = r_didx;
                    n_db_exp = w_done_sel.expiry;
                end
                n_didx = r_didx + 1'b1;
                if (r_didx == DONE_IDX_W'(DONE_DEPTH - 1)) begin
                    n_state = S_REM_WRITE;
                end
            end
            S_REM_WRITE: begin
                w_done_ctl[r_dslot].we = 1'b1;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (w_load) begin
                    n_state = r_res.last ? S_IDLE : S_FL_NEXT;
                end
            end
            S_FL_NEXT: begin
                if (r_due == '0) begin
                    n_state = S_IDLE;
                end else begin
                    n_res.out_key      = w_raw_sel.key;
                    n_res.raw_handle   = w_raw_sel.info[31:16];
                    n_res.fused_handle = '0;
                    n_res.fused_taken  = 1'b0;
                    n_res.cause        = CAUSE_NOFUSED;
                    n_res.wait_ticks   = elapsed(w_raw_sel.arrival, r_now);
                    n_res.last         = ((r_due & ~w_due_bit) == '0);
                    n_rkey = w_raw_sel.key;
                    n_due  = r_due & ~w_due_bit;
                    w_raw_ctl[w_due_idx].clr = 1'b1;
                    n_state = S_REM_LOOK;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_out_valid = r_out_valid;
        n_out_word  = r_out_word;
        if (w_load) begin
            n_out_valid = 1'b1;
            n_out_word  = r_res;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_live      <= 1'b0;
            r_due       <= '0;
            r_holdoff   <= 32'd50000;
            r_lifetime  <= 32'd1000000;
            r_max       <= 5'd16;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_live      <= n_live;
            r_due       <= n_due;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_HOLDOFF:  r_holdoff  <= i_cfg_data;
                    REG_LIFETIME: r_lifetime <= i_cfg_data;
                    REG_MAXPEND:  r_max      <= i_cfg_data[4:0];
                    default: begin
                    end
                endcase
            end
        end
        r_op       <= n_op;
        r_key      <= n_key;
        r_now      <= n_now;
        r_handle   <= n_handle;
        r_points   <= n_points;
        r_colors   <= n_colors;
        r_ovw      <= n_ovw;
        r_tgt      <= n_tgt;
        r_idx      <= n_idx;
        r_rb_ok    <= n_rb_ok;
        r_rb_idx   <= n_rb_idx;
        r_rb_arr   <= n_rb_arr;
        r_fb_ok    <= n_fb_ok;
        r_fb_idx   <= n_fb_idx;
        r_fb_arr   <= n_fb_arr;
        r_didx     <= n_didx;
        r_dslot    <= n_dslot;
        r_db_exp   <= n_db_exp;
        r_rkey     <= n_rkey;
        r_res      <= n_res;
        r_out_word <= n_out_word;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;
    assign o_cfg_ready = 1'b1;

    `TPM_ASSERT_IMPLY(a_room_after_insert, (r_state == S_INSERT), (w_total <= w_lim),
        "pending occupancy above limit at insert")
    `TPM_ASSERT_IMPLY(a_free_slot_for_new,
        (r_state == S_INSERT && !r_ovw && r_live && r_op == OP_RAW),
        w_raw_free_c[PEND_DEPTH], "no free raw slot for a new entry")
    `TPM_ASSERT_IMPLY(a_free_slot_for_fused,
        (r_state == S_INSERT && !r_ovw && r_live && r_op == OP_FUSED),
        w_fus_free_c[PEND_DEPTH], "no free fused slot for a new entry")
    `TPM_ASSERT_IMPLY(a_due_entry_live, (r_state == S_FL_NEXT && r_due != '0),
        w_raw_sel.valid, "flush selects an empty raw slot")
    `TPM_ASSERT_ALWAYS(a_single_raw_hit, $onehot0(w_raw_hit1),
        "more than one first raw hit")

endmodule

### sim/timestamp_pair_matcher_top_tb.sv
`timescale 1ns / 1ps

module timestamp_pair_matcher_top_tb;
    import tpm_pkg::*;

    localparam int NPEND = 16;
    localparam int NDONE = 32;
    localparam logic [47:0] M48 = 48'hFFFF_FFFF_FFFF;

    class pair_scoreboard;
        logic [31:0] holdoff;
        logic [31:0] lifetime;
        logic [4:0]  maxpend;
        bit          rv[NPEND];
        logic [63:0] rk[NPEND];
        logic [15:0] rh[NPEND];
        logic [15:0] rp[NPEND];
        logic [47:0] ra[NPEND];
        logic [47:0] rd[NPEND];
        bit          fv[NPEND];
        logic [63:0] fk[NPEND];
        logic [15:0] fh[NPEND];
        logic [15:0] fp[NPEND];
        logic [15:0] fc[NPEND];
        logic [47:0] fa[NPEND];
        bit          dv[NDONE];
        logic [63:0] dk[NDONE];
        logic [47:0] de[NDONE];
        t_out_word   pending_words[$];
        int          errors;
        int          checked;

        function new();
            holdoff = 32'd50000;
            lifetime = 32'd1000000;
            maxpend = 5'd16;
            errors = 0;
            checked = 0;
            foreach (rv[i]) begin
                rv[i] = 0;
                fv[i] = 0;
            end
            foreach (dv[i]) dv[i] = 0;
        endfunction

        function logic [47:0] add_sat(logic [47:0] a, logic [31:0] b);
            logic [48:0] s;
            s = {1'b0, a} + {17'd0, b};
            return s[48] ? M48 : s[47:0];
        endfunction

        function logic [47:0] span(logic [47:0] from, logic [47:0] upto);
            return (upto >= from) ? upto - from : 48'd0;
        endfunction

        function bit key_done(logic [63:0] k);
            foreach (dv[i]) if (dv[i] && dk[i] == k) return 1;
            return 0;
        endfunction

        function void note_done(logic [63:0] k, logic [47:0] now);
            int s;
            s = -1;
            for (int i = 0; i < NDONE && s < 0; i++) if (dv[i] && dk[i] == k) s = i;
            for (int i = 0; i < NDONE && s < 0; i++) if (!dv[i]) s = i;
            if (s < 0) begin
                s = 0;
                for (int i = 1; i < NDONE; i++) if (de[i] < de[s]) s = i;
            end
            dv[s] = 1;
            dk[s] = k;
            de[s] = add_sat(now, lifetime);
        endfunction

        function int find_raw(logic [63:0] k);
            foreach (rv[i]) if (rv[i] && rk[i] == k) return i;
            return -1;
        endfunction

        function int find_fused(logic [63:0] k);
            foreach (fv[i]) if (fv[i] && fk[i] == k) return i;
            return -1;
        endfunction

        // tbl: 0 raw arrival, 1 fused arrival, -1 none; returns survival of arrival
        function bit evict_oldest(int tbl, logic [47:0] carr);
            int lim, nr, nf, ro, fo;
            bit alive, rc, fcn, r_any, f_any;
            logic [47:0] xa, ya;
            lim = (int'(maxpend) > NPEND) ? NPEND : int'(maxpend);
            alive = tbl >= 0;
            forever begin
                nr = 0; nf = 0; ro = -1; fo = -1;
                for (int i = 0; i < NPEND; i++) begin
                    if (rv[i]) begin
                        nr++;
                        if (ro < 0 || ra[i] < ra[ro]) ro = i;
                    end
                    if (fv[i]) begin
                        nf++;
                        if (fo < 0 || fa[i] < fa[fo]) fo = i;
                    end
                end
                if (nr + nf + (alive ? 1 : 0) <= lim) break;
                rc = alive && tbl == 0 && (ro < 0 || carr < ra[ro]);
                fcn = alive && tbl == 1 && (fo < 0 || carr < fa[fo]);
                r_any = ro >= 0 || rc;
                f_any = fo >= 0 || fcn;
                xa = rc ? carr : (ro >= 0 ? ra[ro] : 48'd0);
                ya = fcn ? carr : (fo >= 0 ? fa[fo] : 48'd0);
                if (!f_any || (r_any && xa <= ya)) begin
                    if (rc) alive = 0; else rv[ro] = 0;
                end else begin
                    if (fcn) alive = 0; else fv[fo] = 0;
                end
            end
            return alive;
        endfunction

        function t_out_word make_word(logic [63:0] k, logic [15:0] rhd, logic [15:0] fhd,
                                      bit used, logic [1:0] cs, logic [47:0] w);
            t_out_word o;
            o.out_key = k;
            o.raw_handle = rhd;
            o.fused_handle = used ? fhd : 16'd0;
            o.fused_taken = used;
            o.cause = cs;
            o.wait_ticks = w;
            o.last = 0;
            return o;
        endfunction

        function void note_config(logic [1:0] idx, logic [31:0] d);
            case (idx)
                REG_HOLDOFF:  holdoff = d;
                REG_LIFETIME: lifetime = d;
                REG_MAXPEND:  maxpend = d[4:0];
                default: ;
            endcase
        endfunction

        function void note_input(t_in_word w);
            t_out_word outs[$];
            int r, f;
            bit ok;
            logic [47:0] now;
            now = w.now_time;
            if (w.opcode == OP_NONE) return;
            foreach (dv[i]) if (dv[i] && now >= de[i]) dv[i] = 0;
            if (w.opcode == OP_RAW) begin
                if (key_done(w.stamp_key)) return;
                f = find_fused(w.stamp_key);
                if (f >= 0) begin
                    ok = fp[f] == w.point_count && fc[f] >= w.point_count;
                    outs.insert(outs.size(), make_word(w.stamp_key, w.item_handle, fh[f], ok,
                                ok ? CAUSE_MERGE : CAUSE_MISMATCH, 48'd0));
                    fv[f] = 0;
                    note_done(w.stamp_key, now);
                end else begin
                    r = find_raw(w.stamp_key);
                    if (r >= 0) void'(evict_oldest(-1, 48'd0));
                    else if (evict_oldest(0, now)) begin
                        foreach (rv[i]) if (!rv[i] && r < 0) r = i;
                    end
                    if (r >= 0) begin
                        rv[r] = 1; rk[r] = w.stamp_key; rh[r] = w.item_handle;
                        rp[r] = w.point_count; ra[r] = now; rd[r] = add_sat(now, holdoff);
                    end
                end
            end else if (w.opcode == OP_FUSED) begin
                if (key_done(w.stamp_key)) return;
                r = find_raw(w.stamp_key);
                if (r >= 0) begin
                    if (now > rd[r])
                        outs.insert(outs.size(), make_word(w.stamp_key, rh[r], 16'd0, 1'b0,
                                    CAUSE_LATE, span(ra[r], now)));
                    else if (w.point_count == rp[r] && w.color_count >= rp[r])
                        outs.insert(outs.size(), make_word(w.stamp_key, rh[r], w.item_handle,
                                    1'b1, CAUSE_MERGE, span(ra[r], now)));
                    else
                        outs.insert(outs.size(), make_word(w.stamp_key, rh[r], 16'd0, 1'b0,
                                    CAUSE_MISMATCH, span(ra[r], now)));
                    rv[r] = 0;
                    note_done(w.stamp_key, now);
                end else begin
                    f = find_fused(w.stamp_key);
                    if (f >= 0) void'(evict_oldest(-1, 48'd0));
                    else if (evict_oldest(1, now)) begin
                        foreach (fv[i]) if (!fv[i] && f < 0) f = i;
                    end
                    if (f >= 0) begin
                        fv[f] = 1; fk[f] = w.stamp_key; fh[f] = w.item_handle;
                        fp[f] = w.point_count; fc[f] = w.color_count; fa[f] = now;
                    end
                end
            end else begin
                for (int i = 0; i < NPEND && outs.size() < 16; i++) begin
                    if (!rv[i] || now < rd[i]) continue;
                    outs.insert(outs.size(), make_word(rk[i], rh[i], 16'd0, 1'b0,
                                CAUSE_NOFUSED, span(ra[i], now)));
                    note_done(rk[i], now);
                    rv[i] = 0;
                end
                for (int i = 0; i < NPEND; i++)
                    if (fv[i] && now >= fa[i] && now - fa[i] >= {16'd0, holdoff}) fv[i] = 0;
            end
            if (outs.size() > 0) outs[outs.size() - 1].last = 1;
            foreach (outs[i]) pending_words.insert(pending_words.size(), outs[i]);
        endfunction

        function void check_word(t_out_word got);
            t_out_word exp_w;
            checked++;
            if (pending_words.size() == 0) begin
                $display("%0t: unexpected word, expected none actual %p", $time, got);
                errors++;
                return;
            end
            exp_w = pending_words.pop_front();
            if (got !== exp_w) begin
                $display("%0t: mismatch expected %p actual %p", $time, exp_w, got);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in_word    i_in_word;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out_word   o_out_word;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [31:0] i_cfg_data;

    pair_scoreboard sb;
    int send_idle_pct;
    int recv_idle_pct;
    int word_count;
    logic [47:0] clock_now;
    logic [63:0] key_pool[8];

    timestamp_pair_matcher_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_word(i_in_word),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_word(o_out_word),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_word = '0;
        i_out_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        sb = new();
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
            if (o_out_valid && !i_out_stall) sb.check_word(o_out_word);
        end
    end

    task automatic send_word(t_in_word w);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word <= w;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_input(w);
        word_count++;
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] d);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= d;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.note_config(idx, d);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending_words.size() != 0) @(posedge i_clk);
        repeat (1500) @(posedge i_clk);
    endtask

    task automatic send_item(logic [1:0] op, logic [63:0] k, logic [47:0] now,
                             logic [15:0] h, logic [15:0] p, logic [15:0] c);
        t_in_word w;
        w.opcode = op;
        w.stamp_key = k;
        w.now_time = now;
        w.item_handle = h;
        w.point_count = p;
        w.color_count = c;
        send_word(w);
    endtask

    task automatic random_phase(int n);
        logic [63:0] k;
        logic [15:0] p;
        int pick;
        for (int i = 0; i < n; i++) begin
            clock_now = clock_now + 48'($urandom_range(40));
            if ($urandom_range(99) < 3) clock_now = 48'({$urandom, $urandom});
            k = key_pool[$urandom_range(7)] + 64'($urandom_range(5));
            if ($urandom_range(99) < 10) k = {$urandom, $urandom};
            p = $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(4));
            pick = $urandom_range(99);
            if (pick < 70) begin
                send_item($urandom_range(1) ? OP_RAW : OP_FUSED, k, clock_now,
                          16'($urandom), p, p);
                send_item(($urandom_range(1)) ? OP_FUSED : OP_RAW, k,
                          clock_now + 48'($urandom_range(60)), 16'($urandom),
                          $urandom_range(4) == 0 ? 16'($urandom) : p,
                          $urandom_range(4) == 0 ? 16'($urandom)
                                                 : p + 16'($urandom_range(2)));
                i++;
            end else if (pick < 82) begin
                send_item(OP_FLUSH, 64'($urandom), clock_now, 16'($urandom),
                          16'($urandom), 16'($urandom));
            end else if (pick < 85) begin
                send_item(OP_NONE, k, clock_now, 16'($urandom), 16'($urandom),
                          16'($urandom));
            end else begin
                send_item(2'($urandom_range(1)), k, clock_now, 16'($urandom), p,
                          16'($urandom));
            end
        end
    endtask

    initial begin
        word_count = 0;
        clock_now = 48'd1000;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};

        send_item(OP_RAW, 64'd0, 48'd0, 16'd0, 16'd0, 16'd0);
        send_item(OP_FUSED, 64'd0, 48'd5, 16'hFFFF, 16'd0, 16'd0);
        send_item(OP_FUSED, '1, M48 - 48'd10, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_item(OP_RAW, '1, M48 - 48'd8, 16'hFFFF, 16'hFFFF, 16'd0);
        send_item(OP_RAW, '1, M48, 16'h1234, 16'd1, 16'd1);
        send_item(OP_RAW, 64'd7, 48'd100, 16'd7, 16'd3, 16'd0);
        send_item(OP_FUSED, 64'd7, 48'd90, 16'd8, 16'd3, 16'd2);
        send_item(OP_RAW, 64'd8, 48'd100, 16'd9, 16'd3, 16'd0);
        send_item(OP_RAW, 64'd8, 48'd120, 16'd10, 16'd4, 16'd0);
        send_item(OP_FUSED, 64'd8, 48'd200000, 16'd11, 16'd4, 16'd4);
        send_item(OP_RAW, 64'd9, 48'd300, 16'd12, 16'd5, 16'd0);
        send_item(OP_FLUSH, 64'd0, 48'd100000, 16'd0, 16'd0, 16'd0);
        send_item(OP_NONE, 64'd3, 48'd100000, 16'd1, 16'd1, 16'd1);
        send_item(OP_FUSED, 64'd20, 48'd300, 16'd13, 16'd2, 16'd2);
        send_item(OP_FLUSH, 64'd0, 48'd100000, 16'd0, 16'd0, 16'd0);
        drain();

        write_reg(REG_HOLDOFF, 32'd0);
        write_reg(REG_LIFETIME, 32'd0);
        write_reg(REG_MAXPEND, 32'd0);
        send_item(OP_RAW, 64'd30, 48'd10, 16'd1, 16'd1, 16'd1);
        send_item(OP_FUSED, 64'd30, 48'd10, 16'd2, 16'd1, 16'd1);
        write_reg(REG_MAXPEND, 32'd31);
        write_reg(REG_LIFETIME, 32'd500);
        for (int i = 0; i < 18; i++)
            send_item(OP_RAW, 64'd40 + 64'(i), 48'd20 - 48'(i % 3), 16'(i), 16'd1, 16'd1);
        send_item(OP_FLUSH, 64'd0, 48'd30, 16'd0, 16'd0, 16'd0);
        for (int i = 0; i < 34; i++)
            send_item(OP_FUSED, 64'd40 + 64'(i), 48'd40 + 48'(i), 16'(i), 16'd1, 16'd1);
        drain();

        send_idle_pct = 6;
        recv_idle_pct = 82;
        write_reg(REG_HOLDOFF, 32'd50);
        write_reg(REG_LIFETIME, 32'd300);
        write_reg(REG_MAXPEND, 32'd4);
        random_phase(100);
        drain();

        send_idle_pct = 82;
        recv_idle_pct = 6;
        write_reg(REG_HOLDOFF, 32'hFFFF_FFFF);
        write_reg(REG_LIFETIME, 32'hFFFF_FFFF);
        write_reg(REG_MAXPEND, 32'd1);
        random_phase(60);
        send_item(OP_FLUSH, 64'd0, M48, 16'd0, 16'd0, 16'd0);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(REG_HOLDOFF, 32'd30);
        write_reg(REG_LIFETIME, 32'd2000);
        write_reg(REG_MAXPEND, 32'd16);
        random_phase(80);
        clock_now = clock_now + 48'd1000;
        send_item(OP_FLUSH, 64'd0, clock_now, 16'd0, 16'd0, 16'd0);
        drain();

        $display("Covered %0d input words and %0d output words over five register settings",
                 word_count, sb.checked);
        $display("including directed extremes, evictions, late pairs and flush bursts.");
        if (sb.errors == 0 && sb.pending_words.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #60ms;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
